// ===== hw/rtl/sbt_pkg.sv =====
package sbt_pkg;

	// Field widths
	localparam int IDX_W   = 10;
	localparam int AMP_W   = 24;
	localparam int FREQ_W  = 25;
	localparam int RATIO_W = 18;

	// Source bin product: bin index times inverse ratio, Q16
	localparam int PROD_W = IDX_W + RATIO_W;
	// Frequency product: signed frequency times unsigned ratio (sign bit added)
	localparam int FPROD_W = FREQ_W + RATIO_W + 1;
	// Frequency product after dropping the 16 fraction bits
	localparam int FQ_W = FPROD_W - 16;

	// Defaults
	localparam int NUM_BINS_DEF = 513;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [RATIO_W-1:0] UNITY_Q16 = RATIO_W'(65536);

	// Saturation limits of the output frequency
	localparam logic signed [FQ_W-1:0] FREQ_MAX = FQ_W'(16777215);
	localparam logic signed [FQ_W-1:0] FREQ_MIN = -FQ_W'(16777216);

	// Commands
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATIO   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RATIO = CFG_IDX_W'(1);

	// Classified operation handed from front to back
	typedef struct packed {
		logic rd;     // read that produces a result
		logic wr;     // store into a bin in range
		logic hit;    // output bin and source bin in range
		logic unity;  // ratio is exactly one
	} sbt_op_t;

endpackage

// ===== hw/rtl/sbt_front.sv =====
module sbt_front import sbt_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int ADDR_W   = $clog2(NUM_BINS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [IDX_W-1:0]    bin_index,
	input  logic [AMP_W-1:0]    amp_in,
	input  logic [FREQ_W-1:0]   freq_in,
	input  logic [RATIO_W-1:0]  pitch_ratio,
	input  logic [RATIO_W-1:0]  inverse_ratio,
	output logic                q_valid,
	input  logic                q_ready,
	output sbt_op_t             q_op,
	output logic [ADDR_W-1:0]   q_addr,
	output logic [IDX_W-1:0]    q_bin,
	output logic [AMP_W-1:0]    q_amp,
	output logic [FREQ_W-1:0]   q_freq
);

	logic                v_s1;
	logic                cmd_s1;
	logic [IDX_W-1:0]    bin_s1;
	logic [AMP_W-1:0]    amp_s1;
	logic [FREQ_W-1:0]   freq_s1;
	logic [PROD_W-1:0]   prod_s1;

	logic [PROD_W-1:0]   rnd;
	logic [31:0]         k;
	logic [31:0]         src;
	logic                j_ok;
	logic                k_ok;
	logic                unity;

	assign in_ready = !v_s1 || q_ready;
	assign q_valid  = v_s1;

	// Hold the accepted item and its source bin product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			bin_s1  <= bin_index;
			amp_s1  <= amp_in;
			freq_s1 <= freq_in;
			prod_s1 <= PROD_W'(bin_index) * PROD_W'(inverse_ratio);
		end
	end

	// Round the source bin half up and classify the item
	always_comb begin
		rnd   = prod_s1 + PROD_W'(32768);
		k     = 32'(rnd[PROD_W-1:16]);
		unity = (pitch_ratio == UNITY_Q16);
		j_ok  = 32'(bin_s1) < 32'(NUM_BINS);
		k_ok  = k < 32'(NUM_BINS);
		src   = ((cmd_s1 == CMD_STORE) || unity) ? 32'(bin_s1) : k;

		q_op.rd    = (cmd_s1 == CMD_READ);
		q_op.wr    = (cmd_s1 == CMD_STORE) && j_ok;
		q_op.hit   = j_ok && (unity || k_ok);
		q_op.unity = unity;
		q_addr     = src[ADDR_W-1:0];
		q_bin      = bin_s1;
		q_amp      = amp_s1;
		q_freq     = freq_s1;
	end

endmodule

// ===== hw/rtl/sbt_queue.sv =====
module sbt_queue import sbt_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Write the entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/sbt_back.sv =====
module sbt_back import sbt_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int ADDR_W   = $clog2(NUM_BINS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [RATIO_W-1:0]        pitch_ratio,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  sbt_op_t                   q_op,
	input  logic [ADDR_W-1:0]         q_addr,
	input  logic [IDX_W-1:0]          q_bin,
	input  logic [AMP_W-1:0]          q_amp,
	input  logic [FREQ_W-1:0]         q_freq,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          bin_number,
	output logic [AMP_W-1:0]          amp_out,
	output logic signed [FREQ_W-1:0]  freq_out
);

	logic [AMP_W-1:0]  amp_mem  [NUM_BINS];
	logic [FREQ_W-1:0] freq_mem [NUM_BINS];

	logic adv1;
	logic adv2;
	logic adv3;
	logic pop;

	// Stage 1: memory read
	logic                     v_s1;
	logic [IDX_W-1:0]         bin_s1;
	logic                     hit_s1;
	logic                     unity_s1;
	logic [AMP_W-1:0]         amp_s1;
	logic [FREQ_W-1:0]        freq_s1;

	// Stage 2: frequency product
	logic                     v_s2;
	logic [IDX_W-1:0]         bin_s2;
	logic                     hit_s2;
	logic                     unity_s2;
	logic [AMP_W-1:0]         amp_s2;
	logic [FREQ_W-1:0]        freq_s2;
	logic signed [FPROD_W-1:0] prod_s2;

	// Stage 3: output register
	logic                     v_s3;

	logic signed [FPROD_W-1:0] rnd;
	logic signed [FQ_W-1:0]    q;
	logic signed [FQ_W-1:0]    sat;
	logic [FREQ_W-1:0]         freq_sel;

	assign adv3    = !v_s3 || out_ready;
	assign adv2    = !v_s2 || adv3;
	assign adv1    = !v_s1 || adv2;
	assign q_ready = !q_op.rd || adv1;
	assign pop     = q_valid && q_ready;

	// Store writes and read lookups share one memory port
	always_ff @(posedge clk) begin
		if (pop && q_op.wr) begin
			amp_mem[q_addr]  <= q_amp;
			freq_mem[q_addr] <= q_freq;
		end
		if (pop && q_op.rd) begin
			amp_s1  <= amp_mem[q_addr];
			freq_s1 <= freq_mem[q_addr];
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= pop && q_op.rd;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Carry the read's control fields and multiply
	always_ff @(posedge clk) begin
		if (pop && q_op.rd) begin
			bin_s1   <= q_bin;
			hit_s1   <= q_op.hit;
			unity_s1 <= q_op.unity;
		end
		if (adv2 && v_s1) begin
			bin_s2   <= bin_s1;
			hit_s2   <= hit_s1;
			unity_s2 <= unity_s1;
			amp_s2   <= amp_s1;
			freq_s2  <= freq_s1;
			prod_s2  <= $signed(freq_s1) * $signed({1'b0, pitch_ratio});
		end
	end

	// Round to Q8 with ties upward, then saturate
	always_comb begin
		rnd = prod_s2 + FPROD_W'(32768);
		q   = rnd[FPROD_W-1:16];
		if (q > FREQ_MAX) begin
			sat = FREQ_MAX;
		end else if (q < FREQ_MIN) begin
			sat = FREQ_MIN;
		end else begin
			sat = q;
		end
		freq_sel = unity_s2 ? freq_s2 : sat[FREQ_W-1:0];
	end

	assign out_valid = v_s3;

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			bin_number <= bin_s2;
			amp_out    <= hit_s2 ? amp_s2 : '0;
			freq_out   <= hit_s2 ? freq_sel : '0;
		end
	end

endmodule

// ===== hw/rtl/spectral_bin_transposer_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | command, bin_index, amp_in, freq_in
// result   | out_valid/out_ready  | bin_number, amp_out, freq_out
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready tied high)
//
// One item is taken per cycle unless the front stage is stalled by a full queue.
// A read's result passes the input stage, the queue, the memory read, the
// multiply and the output register before it is presented.
// Stores produce no result but use the memory port.
// The single memory port, shared by stores and reads, sets the rate.
// Reset clears the valid bits and the ratio registers; bin memory is not cleared.
// A stalled result holds the back end while the queue keeps taking items until full.
module spectral_bin_transposer_top import sbt_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [IDX_W-1:0]          bin_index,
	input  logic [AMP_W-1:0]          amp_in,
	input  logic signed [FREQ_W-1:0]  freq_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          bin_number,
	output logic [AMP_W-1:0]          amp_out,
	output logic signed [FREQ_W-1:0]  freq_out,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [RATIO_W-1:0]        cfg_data
);

	localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int OP_W   = $bits(sbt_op_t);
	localparam int QW     = OP_W + ADDR_W + IDX_W + AMP_W + FREQ_W;

	logic [RATIO_W-1:0] pitch_ratio_q;
	logic [RATIO_W-1:0] inverse_ratio_q;

	sbt_op_t            f_op;
	logic [ADDR_W-1:0]  f_addr;
	logic [IDX_W-1:0]   f_bin;
	logic [AMP_W-1:0]   f_amp;
	logic [FREQ_W-1:0]  f_freq;
	logic               f_valid;
	logic               f_ready;

	sbt_op_t            b_op;
	logic [ADDR_W-1:0]  b_addr;
	logic [IDX_W-1:0]   b_bin;
	logic [AMP_W-1:0]   b_amp;
	logic [FREQ_W-1:0]  b_freq;
	logic               b_valid;
	logic               b_ready;

	logic [QW-1:0]      push_data;
	logic [QW-1:0]      pop_data;

	assign cfg_ready = 1'b1;

	// Ratio registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_ratio_q   <= UNITY_Q16;
			inverse_ratio_q <= UNITY_Q16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PITCH_RATIO:   pitch_ratio_q   <= cfg_data;
				REG_INVERSE_RATIO: inverse_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sbt_front #(
		.NUM_BINS (NUM_BINS),
		.ADDR_W   (ADDR_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.bin_index     (bin_index),
		.amp_in        (amp_in),
		.freq_in       (freq_in),
		.pitch_ratio   (pitch_ratio_q),
		.inverse_ratio (inverse_ratio_q),
		.q_valid       (f_valid),
		.q_ready       (f_ready),
		.q_op          (f_op),
		.q_addr        (f_addr),
		.q_bin         (f_bin),
		.q_amp         (f_amp),
		.q_freq        (f_freq)
	);

	assign push_data = {f_op, f_addr, f_bin, f_amp, f_freq};
	assign {b_op, b_addr, b_bin, b_amp, b_freq} = pop_data;

	sbt_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (pop_data)
	);

	sbt_back #(
		.NUM_BINS (NUM_BINS),
		.ADDR_W   (ADDR_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pitch_ratio (pitch_ratio_q),
		.q_valid     (b_valid),
		.q_ready     (b_ready),
		.q_op        (b_op),
		.q_addr      (b_addr),
		.q_bin       (b_bin),
		.q_amp       (b_amp),
		.q_freq      (b_freq),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bin_number  (bin_number),
		.amp_out     (amp_out),
		.freq_out    (freq_out)
	);

endmodule

// ===== hw/rtl/sbt_checker.sv =====
module sbt_checker import sbt_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     command,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [IDX_W-1:0]         bin_number,
	input logic [AMP_W-1:0]         amp_out,
	input logic signed [FREQ_W-1:0] freq_out,
	input logic                     cfg_valid,
	input logic                     cfg_ready
);

	logic [7:0] pending_q;
	logic       rd_xfer;
	logic       out_xfer;

	assign rd_xfer  = in_valid && in_ready && (command == CMD_READ);
	assign out_xfer = out_valid && out_ready;

	// Count reads taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (rd_xfer && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !rd_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_number)
			&& $stable(amp_out) && $stable(freq_out))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a pending read");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(bin_number) >= 32'(NUM_BINS)) |-> amp_out == '0 && freq_out == '0)
		else $error("out of range bin returned nonzero data");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind spectral_bin_transposer_top sbt_checker #(.NUM_BINS(NUM_BINS)) u_sbt_checker (.*);

// ===== test/transpose_board_pkg.sv =====
`timescale 1ns / 1ps

package transpose_board_pkg;
	import sbt_pkg::*;

	localparam int NB = NUM_BINS_DEF;
	localparam longint FREQ_TOP = 64'sd16777215;
	localparam longint FREQ_BOTTOM = -64'sd16777216;

	typedef struct packed {
		logic [IDX_W-1:0]         number;
		logic [AMP_W-1:0]         amp;
		logic signed [FREQ_W-1:0] freq;
	} bin_result_t;

	class transposed_bin_board;
		logic [RATIO_W-1:0]       pitch_ratio;
		logic [RATIO_W-1:0]       inverse_ratio;
		logic [AMP_W-1:0]         amp_mem [NB];
		logic signed [FREQ_W-1:0] freq_mem [NB];
		bit                       written [NB];
		bin_result_t              expected_bins [$];
		int                       faults;

		function new();
			pitch_ratio = UNITY_Q16;
			inverse_ratio = UNITY_Q16;
			faults = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] d);
			case (idx)
				REG_PITCH_RATIO: pitch_ratio = d;
				REG_INVERSE_RATIO: inverse_ratio = d;
				default: ;
			endcase
		endfunction

		// Source bin of output bin j; NB or more means no source in the frame
		function int source_bin(logic [IDX_W-1:0] j);
			logic [PROD_W:0] prod;
			if (j >= NB)
				return NB;
			if (pitch_ratio == UNITY_Q16)
				return int'(j);
			prod = (PROD_W+1)'(j) * (PROD_W+1)'(inverse_ratio) + (PROD_W+1)'(32768);
			return int'(prod >> 16);
		endfunction

		function bit read_is_safe(logic [IDX_W-1:0] j);
			int k;
			k = source_bin(j);
			return (k >= NB) || written[k];
		endfunction

		// Round Q24 product to Q8, ties toward plus infinity, then saturate
		function logic signed [FREQ_W-1:0] scale_freq(logic signed [FREQ_W-1:0] f);
			longint prod;
			prod = longint'(f) * longint'(pitch_ratio) + 32768;
			prod = prod >>> 16;
			if (prod > FREQ_TOP)
				prod = FREQ_TOP;
			if (prod < FREQ_BOTTOM)
				prod = FREQ_BOTTOM;
			return FREQ_W'(prod);
		endfunction

		// Apply a store, or queue the transposed bin a read must return
		function void note_item(logic cmd, logic [IDX_W-1:0] j, logic [AMP_W-1:0] a,
				logic signed [FREQ_W-1:0] f);
			bin_result_t e;
			int k;
			if (cmd == CMD_STORE) begin
				if (j < NB) begin
					amp_mem[j] = a;
					freq_mem[j] = f;
					written[j] = 1'b1;
				end
				return;
			end
			k = source_bin(j);
			e.number = j;
			e.amp = '0;
			e.freq = '0;
			if (k < NB) begin
				e.amp = amp_mem[k];
				e.freq = scale_freq(freq_mem[k]);
			end
			expected_bins.push_back(e);
		endfunction

		function void compare_bin(logic [IDX_W-1:0] number, logic [AMP_W-1:0] amp,
				logic signed [FREQ_W-1:0] freq);
			bin_result_t e;
			if (expected_bins.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: bin %0d amp 0x%06h freq %0d", number, amp, freq);
				return;
			end
			e = expected_bins.pop_front();
			if (number !== e.number || amp !== e.amp || freq !== e.freq) begin
				faults++;
				if (faults <= 10)
					$display("result error: expected bin %0d amp 0x%06h freq %0d, got bin %0d amp 0x%06h freq %0d",
						e.number, e.amp, e.freq, number, amp, freq);
			end
		endfunction

		function int pending();
			return expected_bins.size();
		endfunction
	endclass

endpackage

// ===== test/tb_spectral_bin_transposer_top.sv =====
`timescale 1ns / 1ps

module tb_spectral_bin_transposer_top;
	import sbt_pkg::*;
	import transpose_board_pkg::*;

	localparam logic [RATIO_W-1:0] RATIO_LO = RATIO_W'(32768);
	localparam logic [RATIO_W-1:0] RATIO_HI = RATIO_W'(131072);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
	localparam logic [AMP_W-1:0] AMP_ALL = '1;
	localparam logic signed [FREQ_W-1:0] FREQ_TOP_V = 25'sh0FFFFFF;
	localparam logic signed [FREQ_W-1:0] FREQ_BOT_V = 25'sh1000000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 55;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [IDX_W-1:0] bin_index;
	logic [AMP_W-1:0] amp_in;
	logic signed [FREQ_W-1:0] freq_in;
	logic out_valid;
	logic out_ready;
	logic [IDX_W-1:0] bin_number;
	logic [AMP_W-1:0] amp_out;
	logic signed [FREQ_W-1:0] freq_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATIO_W-1:0] cfg_data;

	logic rx_want = 1'b0;
	logic rx_hold = 1'b0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_start = 1'b0;

	transposed_bin_board sb;

	spectral_bin_transposer_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.bin_index  (bin_index),
		.amp_in     (amp_in),
		.freq_in    (freq_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_number (bin_number),
		.amp_out    (amp_out),
		.freq_out   (freq_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign out_ready = rx_want & ~rx_hold;

	// Check every result transfer against the oldest expected bin
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.compare_bin(bin_number, amp_out, freq_out);
	end

	// Result side: random wait before each transfer
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			n = rx_quiet ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				rx_want <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rx_want <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// Hold off the result side for a long stretch so the block backs up
	initial begin
		wait (hold_start);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [AMP_W-1:0] rand_amp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return AMP_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [FREQ_W-1:0] rand_freq();
		case ($urandom_range(0, 9))
			0: return FREQ_BOT_V;
			1: return FREQ_TOP_V;
			2: return FREQ_W'(int'($urandom_range(0, 4000)) - 2000);
			default: return FREQ_W'($urandom);
		endcase
	endfunction

	// Offer one item after a random gap; called at a falling edge
	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic [AMP_W-1:0] amp, input logic signed [FREQ_W-1:0] freq);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd;
		bin_index <= idx;
		amp_in <= amp;
		freq_in <= freq;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_item(cmd, idx, amp, freq);
		@(negedge clk);
	endtask

	// Stop offering, wait for every expected bin, then let stores retire
	task automatic drain_block();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Hold valid high across back-to-back writes; caller lowers it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.write_reg(idx, d);
		@(negedge clk);
	endtask

	task automatic program_ratios(input logic [RATIO_W-1:0] pitch,
			input logic [RATIO_W-1:0] inverse, input bit spare);
		drain_block();
		cfg_write(REG_PITCH_RATIO, pitch);
		cfg_write(REG_INVERSE_RATIO, inverse);
		if (spare)
			cfg_write(REG_SPARE, RATIO_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Mostly stores and legal reads; store the source bin first if needed
	task automatic run_random(input int count);
		int sel;
		logic [IDX_W-1:0] j;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				send_item(CMD_STORE, IDX_W'($urandom_range(0, NB - 1)), rand_amp(),
					rand_freq());
			end else if (sel < 50) begin
				send_item(CMD_STORE, IDX_W'($urandom_range(NB, 1023)), rand_amp(),
					rand_freq());
			end else begin
				j = (sel < 93) ? IDX_W'($urandom_range(0, NB - 1)) :
					IDX_W'($urandom_range(NB, 1023));
				if (!sb.read_is_safe(j))
					send_item(CMD_STORE, IDX_W'(sb.source_bin(j)), rand_amp(), rand_freq());
				send_item(CMD_READ, j, rand_amp(), rand_freq());
			end
		end
	endtask

	initial begin
		int ph;
		int r;
		longint inv;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_STORE;
		bin_index = '0;
		amp_in = '0;
		freq_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PITCH_RATIO;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Store extremes at both ends of the frame, plus ignored stores past it
		send_item(CMD_STORE, 0, '0, '0);
		send_item(CMD_STORE, IDX_W'(NB - 1), AMP_ALL, FREQ_TOP_V);
		send_item(CMD_STORE, 1, AMP_ALL, FREQ_BOT_V);
		send_item(CMD_STORE, 2, 24'h555555, -25'sd1);
		send_item(CMD_STORE, 256, 24'hAAAAAA, FREQ_TOP_V);
		send_item(CMD_STORE, IDX_W'(NB), AMP_ALL, '0);
		send_item(CMD_STORE, 10'h3FF, 24'h123456, FREQ_BOT_V);

		// Unit ratio passes bins through; reads past the frame return zeros
		send_item(CMD_READ, 0, '0, '0);
		send_item(CMD_READ, 1, '0, '0);
		send_item(CMD_READ, 2, '0, '0);
		send_item(CMD_READ, IDX_W'(NB - 1), '0, '0);
		send_item(CMD_READ, IDX_W'(NB), '0, '0);
		send_item(CMD_READ, 10'h3FF, '0, '0);

		// Ratio two: saturate both ways
		program_ratios(RATIO_HI, RATIO_LO, 1'b0);
		send_item(CMD_READ, 1, '0, '0);
		send_item(CMD_READ, 4, '0, '0);
		send_item(CMD_READ, 512, '0, '0);
		send_item(CMD_READ, 1000, '0, '0);

		// Ratio one half: source past the last bin gives zeros
		program_ratios(RATIO_LO, RATIO_HI, 1'b0);
		send_item(CMD_READ, 256, '0, '0);
		send_item(CMD_READ, 257, '0, '0);
		send_item(CMD_READ, 1, '0, '0);

		// Unit ratio ignores the inverse register
		program_ratios(UNITY_Q16, RATIO_HI, 1'b1);
		send_item(CMD_READ, 1, '0, '0);
		send_item(CMD_READ, 512, '0, '0);

		for (ph = 0; ph < 9; ph++) begin
			case (ph)
				0: program_ratios(UNITY_Q16, UNITY_Q16, 1'b0);
				1: program_ratios(RATIO_HI, RATIO_LO, 1'b0);
				2: program_ratios(RATIO_LO, RATIO_HI, 1'b1);
				3: program_ratios(UNITY_Q16, RATIO_W'($urandom_range(32768, 131072)), 1'b0);
				default: begin
					r = $urandom_range(32768, 131072);
					inv = ((longint'(1) << 32) + r / 2) / r;
					if ($urandom_range(0, 3) == 0)
						inv = $urandom_range(32768, 131072);
					if (inv < 32768)
						inv = 32768;
					if (inv > 131072)
						inv = 131072;
					program_ratios(RATIO_W'(r), RATIO_W'(inv), 1'b0);
				end
			endcase
			tx_quiet = (ph == 5) || (ph == 7);
			rx_quiet = (ph == 7);
			if (ph == 5)
				hold_start = 1'b1;
			run_random(PHASE_ITEMS);
		end

		drain_block();
		if (sb.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
